// ===== src/pgsb_pkg.sv =====
// ----------------------------------------------------------------------------
// pgsb_pkg
// Shared constants for the packed grayscale shift buffer: store geometry,
// level limits and command codes.
// ----------------------------------------------------------------------------
package pgsb_pkg;

	localparam int MAX_DEVICES        = 8;
	localparam int CHANNELS_PER_DEVICE = 24;

	// two 12-bit channels share one 24-bit word (three packed bytes)
	localparam int WORD_W          = 24;
	localparam int WORDS_PER_DEV   = CHANNELS_PER_DEVICE / 2;
	localparam int STORE_WORDS     = WORDS_PER_DEV * MAX_DEVICES;
	localparam int ADDR_W          = $clog2(STORE_WORDS);

	localparam int LEVEL_W = 12;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_SEND  = 2'd2;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

endpackage

// ===== src/pgsb_ram.sv =====
// ----------------------------------------------------------------------------
// pgsb_ram
// Packed level store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pgsb_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [pgsb_pkg::ADDR_W-1:0] waddr,
	input  logic [pgsb_pkg::WORD_W-1:0] wdata,
	input  logic [pgsb_pkg::ADDR_W-1:0] raddr,
	output logic [pgsb_pkg::WORD_W-1:0] rdata_s1
);
	import pgsb_pkg::*;

	logic [WORD_W-1:0] mem [STORE_WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

endmodule

// ===== src/packed_grayscale_shift_buffer.sv =====
// ----------------------------------------------------------------------------
// packed_grayscale_shift_buffer
// Grayscale level store for chained 24-channel PWM drivers, two 12-bit
// levels packed into three bytes. Writes clamp and merge, reads unpack,
// a send streams the packed bytes out highest index first, eight per result (the last result holds four or eight).
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------
//  request   | start / busy           | mode, channel, level
//  result    | result_strobe          | read_level, status, serial_bytes,
//            |                        | byte_count, last
//  config    | cfg_we                 | cfg_wdata (device count)
//
//  write and read: the store is read as the request is taken, then the
//  access state merges and writes back (the store read data is registered)
//  a send reads one store word (3 bytes) a cycle
//  out-of-range requests answer straight from idle and leave the store alone
//  after reset a clearing pass zeroes all 96 store words, busy stays high
//  the receiver cannot stall: every result is shown for exactly one cycle
// ----------------------------------------------------------------------------
module packed_grayscale_shift_buffer (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic [7:0]                   channel,
	input  logic [15:0]                  level,
	// result channel
	output logic                         result_strobe,
	output logic [pgsb_pkg::LEVEL_W-1:0] read_level,
	output logic                         status,
	output logic [63:0]                  serial_bytes,
	output logic [3:0]                   byte_count,
	output logic                         last,
	// configuration
	input  logic                         cfg_we,
	input  logic [3:0]                   cfg_wdata
);
	import pgsb_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_SEND,
		ST_SEND_END
	} state_t;

	state_t              state_q;
	logic [3:0]          device_count_q;
	logic [ADDR_W-1:0]   clr_ptr_q;
	logic [ADDR_W-1:0]   rd_ptr_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                odd_q;
	logic                is_write_q;
	logic [LEVEL_W-1:0]  lvl_q;
	logic                send_vld_s1;
	logic                send_fin_s1;
	logic [79:0]         acc_q;
	logic [3:0]          fill_q;

	// memory port
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [WORD_W-1:0]   wdata;
	logic [ADDR_W-1:0]   raddr;
	logic [WORD_W-1:0]   rdata_s1;

	// request decode
	logic                accept;
	logic [3:0]          devs;
	logic [7:0]          nch;
	logic [ADDR_W-1:0]   words;
	logic                ch_ok;
	logic [LEVEL_W-1:0]  lvl_clamped;

	// send byte assembly
	logic [WORD_W-1:0]   ordered;
	logic [79:0]         acc_app;
	logic [3:0]          fill_app;

	pgsb_ram u_ram (
		.clk      (clk),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.raddr    (raddr),
		.rdata_s1 (rdata_s1)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// device count: zero acts as one, anything above the maximum saturates
	always_comb begin
		if (device_count_q == 4'd0) begin
			devs = 4'd1;
		end else if (device_count_q > 4'(MAX_DEVICES)) begin
			devs = 4'(MAX_DEVICES);
		end else begin
			devs = device_count_q;
		end
	end

	// 24 channels and 12 words per device
	assign nch   = {devs, 4'b0000} + {1'b0, devs, 3'b000};
	assign words = {devs, 3'b000} + {1'b0, devs, 2'b00};
	assign ch_ok = (channel < nch);

	assign lvl_clamped = (|level[15:LEVEL_W]) ? LEVEL_MAX : level[LEVEL_W-1:0];

	// store access: clearing pass, write-back of a merged word, send walk
	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = odd_q ? {lvl_q, rdata_s1[LEVEL_W-1:0]}
		              : {rdata_s1[WORD_W-1:LEVEL_W], lvl_q};
		raddr = channel[7:1];
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_ptr_q;
				wdata = '0;
			end
			ST_ACCESS: begin
				we = is_write_q;
			end
			ST_SEND: begin
				raddr = rd_ptr_q;
			end
			default: begin
			end
		endcase
	end

	// word holds bytes 3k (low) to 3k+2 (high); transmit highest byte first
	assign ordered  = {rdata_s1[7:0], rdata_s1[15:8], rdata_s1[23:16]};
	assign acc_app  = acc_q | ({56'b0, ordered} << {fill_q, 3'b000});
	assign fill_app = fill_q + 4'd3;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_count_q <= 4'd1;
		end else if (cfg_we) begin
			device_count_q <= cfg_wdata;
		end
	end

	// sequencer and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_ptr_q     <= '0;
			rd_ptr_q      <= '0;
			addr_q        <= '0;
			odd_q         <= 1'b0;
			is_write_q    <= 1'b0;
			lvl_q         <= '0;
			send_vld_s1   <= 1'b0;
			send_fin_s1   <= 1'b0;
			acc_q         <= '0;
			fill_q        <= '0;
			result_strobe <= 1'b0;
			read_level    <= '0;
			status        <= STATUS_OK;
			serial_bytes  <= '0;
			byte_count    <= '0;
			last          <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			send_vld_s1   <= 1'b0;
			send_fin_s1   <= 1'b0;

			unique case (state_q)
				ST_CLEAR: begin
					clr_ptr_q <= clr_ptr_q + 1'b1;
					if (clr_ptr_q == ADDR_W'(STORE_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end

				ST_IDLE: begin
					if (accept) begin
						addr_q     <= channel[7:1];
						odd_q      <= channel[0];
						lvl_q      <= lvl_clamped;
						is_write_q <= (mode == MODE_WRITE);
						unique case (mode) inside
							MODE_WRITE, MODE_READ: begin
								if (ch_ok) begin
									state_q <= ST_ACCESS;
								end else begin
									// out of range: flag it, store untouched
									result_strobe <= 1'b1;
									read_level    <= '0;
									status        <= STATUS_RANGE;
									serial_bytes  <= '0;
									byte_count    <= '0;
									last          <= 1'b1;
								end
							end
							MODE_SEND: begin
								rd_ptr_q <= words - 1'b1;
								acc_q    <= '0;
								fill_q   <= '0;
								state_q  <= ST_SEND;
							end
							default: begin
								// unused code: no result
							end
						endcase
					end
				end

				ST_ACCESS: begin
					result_strobe <= 1'b1;
					read_level    <= is_write_q ? '0
					               : (odd_q ? rdata_s1[WORD_W-1:LEVEL_W]
					                        : rdata_s1[LEVEL_W-1:0]);
					status        <= STATUS_OK;
					serial_bytes  <= '0;
					byte_count    <= '0;
					last          <= 1'b1;
					state_q       <= ST_IDLE;
				end

				ST_SEND: begin
					send_vld_s1 <= 1'b1;
					send_fin_s1 <= (rd_ptr_q == '0);
					if (rd_ptr_q == '0) begin
						state_q <= ST_SEND_END;
					end else begin
						rd_ptr_q <= rd_ptr_q - 1'b1;
					end
				end

				ST_SEND_END: begin
					state_q <= ST_IDLE;
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// byte assembly runs alongside the walk, one word behind it
			if (send_vld_s1) begin
				if (send_fin_s1) begin
					// totals are a multiple of four bytes: the tail is 4 or 8
					result_strobe <= 1'b1;
					read_level    <= '0;
					status        <= STATUS_OK;
					serial_bytes  <= acc_app[63:0];
					byte_count    <= fill_app;
					last          <= 1'b1;
					acc_q         <= '0;
					fill_q        <= '0;
				end else if (fill_app >= 4'd8) begin
					result_strobe <= 1'b1;
					read_level    <= '0;
					status        <= STATUS_OK;
					serial_bytes  <= acc_app[63:0];
					byte_count    <= 4'd8;
					last          <= 1'b0;
					acc_q         <= {64'b0, acc_app[79:64]};
					fill_q        <= fill_app - 4'd8;
				end else begin
					acc_q  <= acc_app;
					fill_q <= fill_app;
				end
			end
		end
	end

endmodule
